// File: design/qcs_pkg.sv
// Shared constants and helpers for the quasi-cyclic syndrome core.
// No dependencies; imported by the core top level, the checker and the testbench.
package qcs_pkg;

  localparam int unsigned MAX_LENGTH = 16384;
  localparam int unsigned ADDR_W     = $clog2(MAX_LENGTH);
  localparam int unsigned LEN_W      = $clog2(MAX_LENGTH + 1);
  localparam int unsigned CFG_W      = 15;
  localparam int unsigned STORE_W    = 2;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // zero acts as one, anything above the store depth acts as the full depth
  function automatic logic [LEN_W-1:0] clamp_length(input logic [CFG_W-1:0] value);
    logic [LEN_W-1:0] len;
    len = LEN_W'(value);
    if (value == '0) begin
      len = LEN_W'(1);
    end else if (32'(value) > MAX_LENGTH) begin
      len = LEN_W'(MAX_LENGTH);
    end
    return len;
  endfunction

endpackage

// File: design/quasi_cyclic_syndrome_core.sv
// Top level of the quasi-cyclic syndrome core: control, walk counters, accumulator.
// Depends on qcs_pkg and two qcs_ram instances (key rows and error halves).
//
// Usage:
//   Input channel (in_valid/in_ready): func selects load or query at position.
//   A load writes the two key bits and two error bits at position;
//   a load at or beyond the active length is dropped. Loads give no result.
//   A query walks j = 0..r-1, reading error[j] and key[(i-j) mod r] together,
//   one entry of each store per cycle, and XORs the products into one bit.
//   Output channel (out_valid/out_ready): query_position, syndrome_bit and
//   out_of_range, held in an output register until transferred.
//   A query passes from IDLE through WALK and DRAIN to HOLD when in range
//   and goes straight to HOLD when out of range, with syndrome_bit 0; HOLD
//   loads the result into the output register once it is free. A load leaves in_ready high.
//   One query is in flight at a time; in_ready is low from its transfer
//   until HOLD loads its result, set by the single read port of each store.
//   A stalled receiver holds the result in the output register; a following
//   query finishes its walk and then waits.
//   cfg_we writes active_length (0 acts as 1, above 16384 acts as 16384).
//   Reset: active length 16384, no result pending; store contents undefined.
module quasi_cyclic_syndrome_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [qcs_pkg::CFG_W-1:0]   cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        func,
  input  logic [qcs_pkg::ADDR_W-1:0]  position,
  input  logic                        key_bit_first,
  input  logic                        key_bit_second,
  input  logic                        error_bit_first,
  input  logic                        error_bit_second,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [qcs_pkg::ADDR_W-1:0]  query_position,
  output logic                        syndrome_bit,
  output logic                        out_of_range
);
  import qcs_pkg::*;

  typedef enum logic [1:0] {IDLE, WALK, DRAIN, HOLD} state_t;

  state_t              state;
  logic [LEN_W-1:0]    len_eff;
  logic [ADDR_W-1:0]   last_idx;
  logic [ADDR_W-1:0]   qpos;
  logic [ADDR_W-1:0]   err_idx;
  logic [ADDR_W-1:0]   key_idx;
  logic                rd_valid;
  logic                acc;
  logic                res_syn;
  logic                res_oor;
  logic [STORE_W-1:0]  key_rdata;
  logic [STORE_W-1:0]  err_rdata;
  logic                term;
  logic                in_range;
  logic                load_we;
  logic                res_load;

  assign in_ready = (state == IDLE);
  assign last_idx = ADDR_W'(len_eff - LEN_W'(1));
  assign in_range = (LEN_W'(position) < len_eff);
  assign load_we  = in_valid && in_ready && (func == FUNC_LOAD) && in_range;
  assign term     = ^(key_rdata & err_rdata);
  assign res_load = (state == HOLD) && (!out_valid || out_ready);

  qcs_ram #(.WIDTH(STORE_W), .DEPTH(MAX_LENGTH)) u_key_ram (
    .clk   (clk),
    .we    (load_we),
    .waddr (position),
    .wdata ({key_bit_second, key_bit_first}),
    .raddr (key_idx),
    .rdata (key_rdata)
  );

  qcs_ram #(.WIDTH(STORE_W), .DEPTH(MAX_LENGTH)) u_err_ram (
    .clk   (clk),
    .we    (load_we),
    .waddr (position),
    .wdata ({error_bit_second, error_bit_first}),
    .raddr (err_idx),
    .rdata (err_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      len_eff   <= LEN_W'(MAX_LENGTH);
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        len_eff <= clamp_length(cfg_wdata);
      end
      rd_valid <= (state == WALK);
      if (rd_valid) begin
        acc <= acc ^ term;
      end
      if (out_ready && !res_load) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (in_valid && (func == FUNC_QUERY)) begin
            qpos    <= position;
            err_idx <= '0;
            key_idx <= position;
            acc     <= 1'b0;
            if (in_range) begin
              state <= WALK;
            end else begin
              res_syn <= 1'b0;
              res_oor <= 1'b1;
              state   <= HOLD;
            end
          end
        end
        WALK: begin
          if (err_idx == last_idx) begin
            state <= DRAIN;
          end else begin
            err_idx <= err_idx + ADDR_W'(1);
            key_idx <= (key_idx == '0) ? last_idx : key_idx - ADDR_W'(1);
          end
        end
        DRAIN: begin
          res_syn <= acc ^ term;
          res_oor <= 1'b0;
          state   <= HOLD;
        end
        HOLD: begin
          if (res_load) begin
            out_valid      <= 1'b1;
            query_position <= qpos;
            syndrome_bit   <= res_syn;
            out_of_range   <= res_oor;
            state          <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// File: design/qcs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module qcs_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/qcs_checker.sv
// Port-level checks for quasi_cyclic_syndrome_core, attached by bind.
// Depends on qcs_pkg for port widths.
module qcs_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       func,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [qcs_pkg::ADDR_W-1:0] query_position,
  input logic                       syndrome_bit,
  input logic                       out_of_range
);
  import qcs_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(query_position)
      && $stable(syndrome_bit) && $stable(out_of_range))
    else $error("result changed while stalled");

  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_of_range |-> !syndrome_bit)
    else $error("out-of-range result with syndrome bit set");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (func == FUNC_QUERY) |=> !in_ready)
    else $error("input taken straight after a query transfer");

  a_load_quick: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (func == FUNC_LOAD) |=> in_ready)
    else $error("load did not complete in one cycle");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a query in progress");

endmodule

bind quasi_cyclic_syndrome_core qcs_checker u_qcs_checker (.*);

// File: tb/sv/tb_quasi_cyclic_syndrome_core.sv
`timescale 1ns / 100ps
// Testbench for quasi_cyclic_syndrome_core: a directed table and random load/query
// phases over several active lengths, results checked vs. table or local predictor.
// Depends on qcs_pkg and the RTL of the core.
module tb_quasi_cyclic_syndrome_core;
  import qcs_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 4 * (MAX_LENGTH + 40);
  localparam int unsigned DIRECTED_ROWS  = 25;
  localparam int unsigned RANDOM_PHASES  = 5;
  localparam int unsigned PHASE_ITEMS    = 12;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

  // h_bits/e_bits: bit 0 first row/half, bit 1 second
  typedef struct packed {
    row_kind_t         kind;
    logic [CFG_W-1:0]  length;
    logic              op;
    logic [ADDR_W-1:0] pos;
    logic [1:0]        h_bits;
    logic [1:0]        e_bits;
    logic              typed;
    logic              syn;
    logic              oor;
  } stim_row_t;

  typedef struct packed {
    logic [ADDR_W-1:0] pos;
    logic              syn;
    logic              oor;
  } syndrome_result_t;

  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{ROW_CFG,  15'd0,     FUNC_LOAD,  14'd0,     2'b00, 2'b00, 1'b0, 1'b0, 1'b0},
    '{ROW_ITEM, 15'd0,     FUNC_LOAD,  14'd0,     2'b11, 2'b11, 1'b0, 1'b0, 1'b0},
    '{ROW_ITEM, 15'd0,     FUNC_QUERY, 14'd0,     2'b00, 2'b00, 1'b1, 1'b0, 1'b0},
    '{ROW_ITEM, 15'd0,     FUNC_QUERY, 14'd1,     2'b00, 2'b00, 1'b1, 1'b0, 1'b1},
    '{ROW_ITEM, 15'd0,     FUNC_QUERY, 14'd16383, 2'b00, 2'b00, 1'b1, 1'b0, 1'b1},
    '{ROW_ITEM, 15'd0,     FUNC_LOAD,  14'd16383, 2'b11, 2'b11, 1'b0, 1'b0, 1'b0},
    '{ROW_ITEM, 15'd0,     FUNC_LOAD,  14'd1,     2'b11, 2'b11, 1'b0, 1'b0, 1'b0},
    '{ROW_ITEM, 15'd0,     FUNC_LOAD,  14'd0,     2'b01, 2'b01, 1'b0, 1'b0, 1'b0},
    '{ROW_ITEM, 15'd0,     FUNC_QUERY, 14'd0,     2'b00, 2'b00, 1'b1, 1'b1, 1'b0},
    '{ROW_CFG,  15'd1,     FUNC_LOAD,  14'd0,     2'b00, 2'b00, 1'b0, 1'b0, 1'b0},
    '{ROW_ITEM, 15'd0,     FUNC_LOAD,  14'd0,     2'b10, 2'b11, 1'b0, 1'b0, 1'b0},
    '{ROW_ITEM, 15'd0,     FUNC_QUERY, 14'd0,     2'b00, 2'b00, 1'b1, 1'b1, 1'b0},
    '{ROW_CFG,  15'd4,     FUNC_LOAD,  14'd0,     2'b00, 2'b00, 1'b0, 1'b0, 1'b0},
    '{ROW_ITEM, 15'd0,     FUNC_LOAD,  14'd1,     2'b11, 2'b10, 1'b0, 1'b0, 1'b0},
    '{ROW_ITEM, 15'd0,     FUNC_LOAD,  14'd2,     2'b00, 2'b01, 1'b0, 1'b0, 1'b0},
    '{ROW_ITEM, 15'd0,     FUNC_LOAD,  14'd3,     2'b01, 2'b11, 1'b0, 1'b0, 1'b0},
    '{ROW_ITEM, 15'd0,     FUNC_QUERY, 14'd0,     2'b00, 2'b00, 1'b0, 1'b0, 1'b0},
    '{ROW_ITEM, 15'd0,     FUNC_QUERY, 14'd1,     2'b00, 2'b00, 1'b0, 1'b0, 1'b0},
    '{ROW_ITEM, 15'd0,     FUNC_QUERY, 14'd2,     2'b00, 2'b00, 1'b0, 1'b0, 1'b0},
    '{ROW_ITEM, 15'd0,     FUNC_QUERY, 14'd3,     2'b00, 2'b00, 1'b0, 1'b0, 1'b0},
    '{ROW_ITEM, 15'd0,     FUNC_QUERY, 14'd4,     2'b00, 2'b00, 1'b1, 1'b0, 1'b1},
    '{ROW_ITEM, 15'd0,     FUNC_LOAD,  14'd4,     2'b11, 2'b11, 1'b0, 1'b0, 1'b0},
    '{ROW_ITEM, 15'd0,     FUNC_QUERY, 14'd3,     2'b00, 2'b00, 1'b0, 1'b0, 1'b0},
    '{ROW_CFG,  15'd32767, FUNC_LOAD,  14'd0,     2'b00, 2'b00, 1'b0, 1'b0, 1'b0},
    '{ROW_ITEM, 15'd0,     FUNC_LOAD,  14'd16383, 2'b11, 2'b11, 1'b0, 1'b0, 1'b0}
  };

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [CFG_W-1:0]  cfg_wdata;
  logic              in_valid;
  logic              in_ready;
  logic              func;
  logic [ADDR_W-1:0] position;
  logic              key_bit_first;
  logic              key_bit_second;
  logic              error_bit_first;
  logic              error_bit_second;
  logic              out_valid;
  logic              out_ready;
  logic [ADDR_W-1:0] query_position;
  logic              syndrome_bit;
  logic              out_of_range;

  logic [1:0]        h_rows [MAX_LENGTH];
  logic [1:0]        e_halves [MAX_LENGTH];
  bit                row_loaded [MAX_LENGTH];
  logic [CFG_W-1:0]  length_reg;
  syndrome_result_t  pending_syndromes [$];
  int unsigned       error_count;
  int unsigned       quiet_cycles;
  bit                idle_bursts;

  quasi_cyclic_syndrome_core DUT (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int unsigned active_len();
    if (length_reg == '0) return 1;
    if (length_reg > MAX_LENGTH) return MAX_LENGTH;
    return int'(length_reg);
  endfunction

  function automatic logic syndrome_of(int unsigned pos, int unsigned len);
    logic        acc;
    int unsigned k;
    acc = 1'b0;
    for (int unsigned j = 0; j < len; j++) begin
      k = (pos >= j) ? pos - j : pos + len - j;
      acc ^= ^(e_halves[j] & h_rows[k]);
    end
    return acc;
  endfunction

  function automatic void note_error(string msg);
    error_count++;
    if (error_count <= 10) $display("mismatch: %s", msg);
  endfunction

  task automatic push_item(input logic op, input logic [ADDR_W-1:0] pos, input logic [1:0] hb,
                           input logic [1:0] eb, input logic typed, input logic t_syn,
                           input logic t_oor);
    syndrome_result_t expected_res;
    int unsigned      len;
    if (idle_bursts && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid         <= 1'b1;
    func             <= op;
    position         <= pos;
    key_bit_first    <= hb[0];
    key_bit_second   <= hb[1];
    error_bit_first  <= eb[0];
    error_bit_second <= eb[1];
    do @(posedge clk); while (!in_ready);
    len = active_len();
    if (op == FUNC_LOAD) begin
      if (pos < len) begin
        h_rows[pos]     = hb;
        e_halves[pos]   = eb;
        row_loaded[pos] = 1'b1;
      end
    end else begin
      expected_res.pos = pos;
      if (typed) begin
        expected_res.syn = t_syn;
        expected_res.oor = t_oor;
      end else begin
        expected_res.oor = (pos >= len);
        expected_res.syn = expected_res.oor ? 1'b0 : syndrome_of(pos, len);
      end
      pending_syndromes.push_back(expected_res);
    end
  endtask

  // wait for every result and a trailing load, then write the length
  task automatic settle_and_configure(input logic [CFG_W-1:0] value);
    in_valid <= 1'b0;
    while (pending_syndromes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we     <= 1'b0;
    length_reg = value;
  endtask

  // every row below len must hold data before an in-range walk
  task automatic fill_rows(input int unsigned len);
    for (int unsigned p = 0; p < len; p++) begin
      if (!row_loaded[p]) begin
        push_item(FUNC_LOAD, ADDR_W'(p), 2'($urandom), 2'($urandom), 1'b0, 1'b0, 1'b0);
      end
    end
  endtask

  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (idle_bursts && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : result_check
    syndrome_result_t got;
    syndrome_result_t want;
    if (!rst && out_valid && out_ready) begin
      got = '{query_position, syndrome_bit, out_of_range};
      if (pending_syndromes.size() == 0) begin
        note_error($sformatf("unexpected transfer pos %0d syn %0b oor %0b",
                             got.pos, got.syn, got.oor));
      end else begin
        want = pending_syndromes.pop_front();
        if (got !== want) begin
          note_error($sformatf("expected pos %0d syn %0b oor %0b, got pos %0d syn %0b oor %0b",
                               want.pos, want.syn, want.oor, got.pos, got.syn, got.oor));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("[quasi_cyclic_syndrome_core] ERROR");
        $finish;
      end
    end
  end

  initial begin
    int unsigned       len;
    logic              op;
    logic [ADDR_W-1:0] pos;
    rst              <= 1'b1;
    cfg_we           <= 1'b0;
    cfg_wdata        <= '0;
    in_valid         <= 1'b0;
    func             <= FUNC_LOAD;
    position         <= '0;
    key_bit_first    <= 1'b0;
    key_bit_second   <= 1'b0;
    error_bit_first  <= 1'b0;
    error_bit_second <= 1'b0;
    quiet_cycles     = 0;
    error_count      = 0;
    idle_bursts      = 1'b1;
    length_reg       = CFG_W'(MAX_LENGTH);
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[r]) begin
      if (DIRECTED[r].kind == ROW_CFG) begin
        settle_and_configure(DIRECTED[r].length);
      end else begin
        push_item(DIRECTED[r].op, DIRECTED[r].pos, DIRECTED[r].h_bits, DIRECTED[r].e_bits,
                  DIRECTED[r].typed, DIRECTED[r].syn, DIRECTED[r].oor);
      end
    end

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      idle_bursts = (ph != RANDOM_PHASES - 1);
      settle_and_configure(CFG_W'($urandom_range(0, 48)));
      len = active_len();
      fill_rows(len);
      repeat (PHASE_ITEMS) begin
        op  = ($urandom_range(0, 1) == 1) ? FUNC_QUERY : FUNC_LOAD;
        pos = ($urandom_range(0, 4) == 0) ? ADDR_W'($urandom_range(len, MAX_LENGTH - 1))
                                          : ADDR_W'($urandom_range(0, len - 1));
        push_item(op, pos, 2'($urandom), 2'($urandom), 1'b0, 1'b0, 1'b0);
      end
    end

    in_valid <= 1'b0;
    while (pending_syndromes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (error_count == 0 && pending_syndromes.size() == 0) begin
      $display("[quasi_cyclic_syndrome_core] OK");
    end else begin
      $display("[quasi_cyclic_syndrome_core] ERROR");
    end
    $finish;
  end

endmodule
